[rtl/power_button_sequencer_macros.svh]
// assertion macros for the power button sequencer
`ifndef POWER_BUTTON_SEQUENCER_MACROS_SVH
`define POWER_BUTTON_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// property that holds at every clock edge out of reset
`define PBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that holds in the cycle after the antecedent
`define PBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PBS_ASSERT(lbl, prop, msg)

`define PBS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/pbs_pkg.sv]
// types, constants and helpers for the power button sequencer
package pbs_pkg;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE      = 7'b000_0001,
    ST_ON_START  = 7'b000_0010,
    ST_ON_WAIT   = 7'b000_0100,
    ST_ON        = 7'b000_1000,
    ST_OFF_START = 7'b001_0000,
    ST_OFF_WAIT  = 7'b010_0000,
    ST_OFF       = 7'b100_0000
  } seq_state_e;

  // state codes as reported on the result beat
  localparam logic [2:0] CODE_IDLE      = 3'd0;
  localparam logic [2:0] CODE_ON_START  = 3'd1;
  localparam logic [2:0] CODE_ON_WAIT   = 3'd2;
  localparam logic [2:0] CODE_ON        = 3'd3;
  localparam logic [2:0] CODE_OFF_START = 3'd4;
  localparam logic [2:0] CODE_OFF_WAIT  = 3'd5;
  localparam logic [2:0] CODE_OFF       = 3'd6;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_FLASH = 2'd2
  } led_mode_e;

  // register indexes
  localparam logic [2:0] REG_PRESCALE_RELOAD = 3'd0;
  localparam logic [2:0] REG_FLASH_RELOAD    = 3'd1;
  localparam logic [2:0] REG_START_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_STOP_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_TURN_OFF_DELAY  = 3'd4;

  // register reset values
  localparam logic [15:0] RST_PRESCALE_RELOAD = 16'd50000;
  localparam logic [15:0] RST_FLASH_RELOAD    = 16'd50000;
  localparam logic [7:0]  RST_START_TIMEOUT   = 8'd200;
  localparam logic [7:0]  RST_STOP_TIMEOUT    = 8'd200;
  localparam logic [7:0]  RST_TURN_OFF_DELAY  = 8'd8;

  function automatic logic [2:0] seq_code(seq_state_e s);
    logic [2:0] c;
    case (s)
      ST_IDLE:      c = CODE_IDLE;
      ST_ON_START:  c = CODE_ON_START;
      ST_ON_WAIT:   c = CODE_ON_WAIT;
      ST_ON:        c = CODE_ON;
      ST_OFF_START: c = CODE_OFF_START;
      ST_OFF_WAIT:  c = CODE_OFF_WAIT;
      ST_OFF:       c = CODE_OFF;
      default:      c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

[rtl/power_button_sequencer.sv]
// power button sequencer top level: filter, timers, sequencer, led drive
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tick: button_level, running_level
//  m_axis    out  m_axis_tvalid/tready    led_on, relay_on, shutdown_request, state
//  apb       in   psel/penable/pready     five timing registers at 4*i
//
// one tick beat in, one result beat out
// the whole tick update is one pass of logic from the state registers into
// the state and result registers; the result beat shows up the cycle after
// its tick is taken, and a new tick enters in the same cycle the previous
// result leaves, so ticks flow every cycle; with m_axis_tready low and the
// result register full the tick input stalls until the result is taken
// reset is asynchronous, active low, and gives idle with all drives off
`include "power_button_sequencer_macros.svh"

module power_button_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] button_level, [1] running_level
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] led_on, [1] relay_on, [2] shutdown_request,
                                      // [5:3] sequence_state
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [15:0] prescale_reload_q;
  logic [15:0] flash_reload_q;
  logic [7:0]  start_timeout_q;
  logic [7:0]  stop_timeout_q;
  logic [7:0]  turn_off_delay_q;

  // sequencer state
  pbs_pkg::seq_state_e state_q, state_d;
  pbs_pkg::led_mode_e  mode_q, mode_d;
  logic        led_q, led_d;
  logic        relay_q, relay_d;
  logic        shdn_q, shdn_d;
  logic [15:0] flash_cnt_q, flash_cnt_d;
  logic [15:0] presc_cnt_q, presc_cnt_d;
  logic [7:0]  off_cnt_q, off_cnt_d;
  logic        btn_prev_q;
  logic        run_prev_q;

  // result register
  logic        out_valid_q;
  logic [7:0]  out_data_q;

  logic        in_fire;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        btn;
  logic        run;
  logic        pressed;
  logic        running;

  // ---------------------------------------------------------------------------
  // apb port: always ready, register index from the word address
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    case (cfg_idx)
      pbs_pkg::REG_PRESCALE_RELOAD: prdata = {16'd0, prescale_reload_q};
      pbs_pkg::REG_FLASH_RELOAD:    prdata = {16'd0, flash_reload_q};
      pbs_pkg::REG_START_TIMEOUT:   prdata = {24'd0, start_timeout_q};
      pbs_pkg::REG_STOP_TIMEOUT:    prdata = {24'd0, stop_timeout_q};
      pbs_pkg::REG_TURN_OFF_DELAY:  prdata = {24'd0, turn_off_delay_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // writes beyond the last register fall into the default arm and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_reload_q <= pbs_pkg::RST_PRESCALE_RELOAD;
      flash_reload_q    <= pbs_pkg::RST_FLASH_RELOAD;
      start_timeout_q   <= pbs_pkg::RST_START_TIMEOUT;
      stop_timeout_q    <= pbs_pkg::RST_STOP_TIMEOUT;
      turn_off_delay_q  <= pbs_pkg::RST_TURN_OFF_DELAY;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pbs_pkg::REG_PRESCALE_RELOAD: prescale_reload_q <= pwdata[15:0];
        pbs_pkg::REG_FLASH_RELOAD:    flash_reload_q    <= pwdata[15:0];
        pbs_pkg::REG_START_TIMEOUT:   start_timeout_q   <= pwdata[7:0];
        pbs_pkg::REG_STOP_TIMEOUT:    stop_timeout_q    <= pwdata[7:0];
        pbs_pkg::REG_TURN_OFF_DELAY:  turn_off_delay_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stream handshake: take a tick whenever the result register is free or
  // is being emptied in this same cycle
  // ---------------------------------------------------------------------------
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // one tick of the sequencer
  // ---------------------------------------------------------------------------
  assign btn = s_axis_tdata[0];
  assign run = s_axis_tdata[1];

  // a level is low only when low on this tick and the one before
  assign pressed = ~btn & ~btn_prev_q;
  assign running = ~(~run & ~run_prev_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    led_d       = led_q;
    relay_d     = relay_q;
    shdn_d      = shdn_q;
    flash_cnt_d = flash_cnt_q;
    presc_cnt_d = presc_cnt_q;
    off_cnt_d   = off_cnt_q;

    // timers first: flash counter counts down to zero, off timer is prescaled
    if (flash_cnt_q != 16'd0) begin
      flash_cnt_d = flash_cnt_q - 16'd1;
    end
    if (off_cnt_q != 8'd0) begin
      if (presc_cnt_q != 16'd0) begin
        presc_cnt_d = presc_cnt_q - 16'd1;
      end else begin
        presc_cnt_d = prescale_reload_q;
        off_cnt_d   = off_cnt_q - 8'd1;
      end
    end

    // sequencer sees the off timer after this tick's decrement
    case (state_q)
      pbs_pkg::ST_IDLE: begin
        if (pressed) state_d = pbs_pkg::ST_ON_START;
      end
      pbs_pkg::ST_ON_START: begin
        // button released: power up and wait for feedback
        if (!pressed) begin
          mode_d    = pbs_pkg::LED_FLASH;
          relay_d   = 1'b1;
          off_cnt_d = start_timeout_q;
          state_d   = pbs_pkg::ST_ON_WAIT;
        end
      end
      pbs_pkg::ST_ON_WAIT: begin
        if (off_cnt_d == 8'd0) begin
          mode_d    = pbs_pkg::LED_OFF;
          relay_d   = 1'b0;
          shdn_d    = 1'b0;
          off_cnt_d = 8'd0;
          state_d   = pbs_pkg::ST_IDLE;
        end else if (running) begin
          off_cnt_d = 8'd0;
          mode_d    = pbs_pkg::LED_ON;
          state_d   = pbs_pkg::ST_ON;
        end
      end
      pbs_pkg::ST_ON: begin
        if (pressed) state_d = pbs_pkg::ST_OFF_START;
      end
      pbs_pkg::ST_OFF_START: begin
        // button released: ask the target to shut down
        if (!pressed) begin
          mode_d    = pbs_pkg::LED_FLASH;
          shdn_d    = 1'b1;
          off_cnt_d = stop_timeout_q;
          state_d   = pbs_pkg::ST_OFF_WAIT;
        end
      end
      pbs_pkg::ST_OFF_WAIT: begin
        if (off_cnt_d == 8'd0) begin
          mode_d    = pbs_pkg::LED_OFF;
          relay_d   = 1'b0;
          shdn_d    = 1'b0;
          off_cnt_d = 8'd0;
          state_d   = pbs_pkg::ST_IDLE;
        end else if (!running) begin
          // feedback gone: hold power for the turn-off delay
          off_cnt_d = turn_off_delay_q;
          state_d   = pbs_pkg::ST_OFF;
        end
      end
      pbs_pkg::ST_OFF: begin
        if (off_cnt_d == 8'd0) begin
          mode_d    = pbs_pkg::LED_OFF;
          relay_d   = 1'b0;
          shdn_d    = 1'b0;
          off_cnt_d = 8'd0;
          state_d   = pbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbs_pkg::ST_IDLE;
      end
    endcase

    // led drive follows the mode chosen above
    case (mode_d)
      pbs_pkg::LED_ON:  led_d = 1'b1;
      pbs_pkg::LED_OFF: led_d = 1'b0;
      pbs_pkg::LED_FLASH: begin
        if (flash_cnt_d == 16'd0) begin
          led_d       = ~led_q;
          flash_cnt_d = flash_reload_q;
        end
      end
      default: begin
        mode_d = pbs_pkg::LED_OFF;
        led_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbs_pkg::ST_IDLE;
      mode_q      <= pbs_pkg::LED_OFF;
      led_q       <= 1'b0;
      relay_q     <= 1'b0;
      shdn_q      <= 1'b0;
      flash_cnt_q <= 16'd0;
      presc_cnt_q <= 16'd0;
      off_cnt_q   <= 8'd0;
      btn_prev_q  <= 1'b1;
      run_prev_q  <= 1'b1;
    end else if (in_fire) begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      led_q       <= led_d;
      relay_q     <= relay_d;
      shdn_q      <= shdn_d;
      flash_cnt_q <= flash_cnt_d;
      presc_cnt_q <= presc_cnt_d;
      off_cnt_q   <= off_cnt_d;
      btn_prev_q  <= btn;
      run_prev_q  <= run;
    end
  end

  // result register: valid flag under reset, payload loaded per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {2'b00, pbs_pkg::seq_code(state_d), shdn_d, relay_d, led_d};
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PBS_ASSERT(a_relay_state, relay_q == !(state_q == pbs_pkg::ST_IDLE || state_q == pbs_pkg::ST_ON_START), "relay drive does not match sequencer state")
  `PBS_ASSERT(a_shdn_relay, !shdn_q || relay_q, "shutdown request raised with relay off")
  `PBS_ASSERT_NEXT(a_beat_out, in_fire, m_axis_tvalid, "accepted tick gave no result beat")

endmodule
